// ===== src/prt_pkg.sv =====
package prt_pkg;

    // Field widths
    localparam int COORD_W = 24;    // vertex coordinate, signed Q16.8
    localparam int RECT_W  = 16;    // rectangle edge, signed integer pixels
    localparam int FRAC_W  = 8;     // fraction bits of the vertex grid
    localparam int AXIS_W  = 25;    // edge component, signed Q17.8

    // Product and dot widths
    localparam int PROD_W  = COORD_W + AXIS_W;      // vertex * axis
    localparam int RPROD_W = RECT_W + AXIS_W;       // rect edge * axis
    localparam int RSUM_W  = RPROD_W + 1;           // sum of two rect products
    localparam int DOT_W   = PROD_W + 2;            // any projection, with margin

    // Lane count: x, y, and the normals of edges v1-v0 and v3-v0
    localparam int LANES   = 4;
    localparam int CORNERS = 4;

    // Lane indexes
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_E1 = 2;
    localparam int LANE_E3 = 3;

    // Work handed to one lane
    typedef struct packed {
        logic                               vld;
        logic signed [AXIS_W-1:0]           ax;
        logic signed [AXIS_W-1:0]           ay;
        logic [CORNERS-1:0][COORD_W-1:0]    px;
        logic [CORNERS-1:0][COORD_W-1:0]    py;
        logic signed [RECT_W-1:0]           rx0;
        logic signed [RECT_W-1:0]           rx1;
        logic signed [RECT_W-1:0]           ry0;
        logic signed [RECT_W-1:0]           ry1;
    } lane_in_t;

    // Projection intervals found by one lane
    typedef struct packed {
        logic                       vld;
        logic signed [DOT_W-1:0]    poly_lo;
        logic signed [DOT_W-1:0]    poly_hi;
        logic signed [DOT_W-1:0]    rect_lo;
        logic signed [DOT_W-1:0]    rect_hi;
    } lane_res_t;

endpackage

// ===== src/prt_lane.sv =====
module prt_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::lane_in_t   lin,
    output prt_pkg::lane_res_t  lres
);

    // Product stage
    logic                                   p_vld_reg;
    logic signed [prt_pkg::PROD_W-1:0]      pxa_reg [prt_pkg::CORNERS];
    logic signed [prt_pkg::PROD_W-1:0]      pya_reg [prt_pkg::CORNERS];
    logic signed [prt_pkg::RPROD_W-1:0]     rxa0_reg, rxa1_reg, rya0_reg, rya1_reg;

    // Dot stage
    logic                                   d_vld_reg;
    logic signed [prt_pkg::DOT_W-1:0]       dot_reg [prt_pkg::CORNERS];
    logic signed [prt_pkg::DOT_W-1:0]       d_rlo_reg, d_rhi_reg;
    logic signed [prt_pkg::DOT_W-1:0]       dot_next [prt_pkg::CORNERS];
    logic signed [prt_pkg::DOT_W-1:0]       d_rlo_next, d_rhi_next;
    logic signed [prt_pkg::RSUM_W-1:0]      rsum_lo, rsum_hi;
    logic signed [prt_pkg::RPROD_W-1:0]     rx_min, rx_max, ry_min, ry_max;

    // Pair min/max stage
    logic                                   m_vld_reg;
    logic signed [prt_pkg::DOT_W-1:0]       lo01_reg, hi01_reg, lo23_reg, hi23_reg;
    logic signed [prt_pkg::DOT_W-1:0]       m_rlo_reg, m_rhi_reg;

    // Final stage
    logic                                   f_vld_reg;
    logic signed [prt_pkg::DOT_W-1:0]       plo_reg, phi_reg, f_rlo_reg, f_rhi_reg;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= lin.vld;
            d_vld_reg <= p_vld_reg;
            m_vld_reg <= d_vld_reg;
            f_vld_reg <= m_vld_reg;
        end
    end

    // Products: each corner coordinate times the axis component
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < prt_pkg::CORNERS; i++)
        begin
            pxa_reg[i] <= $signed(lin.px[i]) * lin.ax;
            pya_reg[i] <= $signed(lin.py[i]) * lin.ay;
        end
        rxa0_reg <= lin.rx0 * lin.ax;
        rxa1_reg <= lin.rx1 * lin.ax;
        rya0_reg <= lin.ry0 * lin.ay;
        rya1_reg <= lin.ry1 * lin.ay;
    end

    // Dots; rect interval is separable per coordinate, then shifted onto the Q16.8 vertex grid
    always_comb
    begin
        for (int i = 0; i < prt_pkg::CORNERS; i++)
        begin
            dot_next[i] = prt_pkg::DOT_W'(pxa_reg[i]) + prt_pkg::DOT_W'(pya_reg[i]);
        end
        rx_min = (rxa0_reg < rxa1_reg) ? rxa0_reg : rxa1_reg;
        rx_max = (rxa0_reg < rxa1_reg) ? rxa1_reg : rxa0_reg;
        ry_min = (rya0_reg < rya1_reg) ? rya0_reg : rya1_reg;
        ry_max = (rya0_reg < rya1_reg) ? rya1_reg : rya0_reg;
        rsum_lo = prt_pkg::RSUM_W'(rx_min) + prt_pkg::RSUM_W'(ry_min);
        rsum_hi = prt_pkg::RSUM_W'(rx_max) + prt_pkg::RSUM_W'(ry_max);
        d_rlo_next = prt_pkg::DOT_W'(rsum_lo) <<< prt_pkg::FRAC_W;
        d_rhi_next = prt_pkg::DOT_W'(rsum_hi) <<< prt_pkg::FRAC_W;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < prt_pkg::CORNERS; i++)
        begin
            dot_reg[i] <= dot_next[i];
        end
        d_rlo_reg <= d_rlo_next;
        d_rhi_reg <= d_rhi_next;
    end

    // Pairwise min/max
    always_ff @(posedge clk)
    begin
        lo01_reg  <= (dot_reg[0] < dot_reg[1]) ? dot_reg[0] : dot_reg[1];
        hi01_reg  <= (dot_reg[0] < dot_reg[1]) ? dot_reg[1] : dot_reg[0];
        lo23_reg  <= (dot_reg[2] < dot_reg[3]) ? dot_reg[2] : dot_reg[3];
        hi23_reg  <= (dot_reg[2] < dot_reg[3]) ? dot_reg[3] : dot_reg[2];
        m_rlo_reg <= d_rlo_reg;
        m_rhi_reg <= d_rhi_reg;
    end

    // Final interval of the parallelogram
    always_ff @(posedge clk)
    begin
        plo_reg   <= (lo01_reg < lo23_reg) ? lo01_reg : lo23_reg;
        phi_reg   <= (hi01_reg < hi23_reg) ? hi23_reg : hi01_reg;
        f_rlo_reg <= m_rlo_reg;
        f_rhi_reg <= m_rhi_reg;
    end

    assign lres.vld     = f_vld_reg;
    assign lres.poly_lo = plo_reg;
    assign lres.poly_hi = phi_reg;
    assign lres.rect_lo = f_rlo_reg;
    assign lres.rect_hi = f_rhi_reg;

    // Checks
    a_lane_latency: assert property (@(posedge clk) disable iff (!rst_n)
        lin.vld |-> ##4 f_vld_reg)
        else $error("lane beat lost in pipeline");

    a_poly_order: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> (plo_reg <= phi_reg))
        else $error("parallelogram interval inverted");

    a_rect_order: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> (f_rlo_reg <= f_rhi_reg))
        else $error("rectangle interval inverted");

endmodule

// ===== src/prt_merge.sv =====
module prt_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::lane_res_t  lres [prt_pkg::LANES],
    output logic                done,
    output logic                overlap
);

    logic                       done_reg;
    logic                       overlap_reg;
    logic [prt_pkg::LANES-1:0]  sep;

    // An axis separates when one interval ends strictly before the other
    always_comb
    begin
        for (int k = 0; k < prt_pkg::LANES; k++)
        begin
            sep[k] = (lres[k].poly_hi < lres[k].rect_lo) ||
                     (lres[k].rect_hi < lres[k].poly_lo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lres[0].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= ~(|sep);
    end

    assign done    = done_reg;
    assign overlap = overlap_reg;

endmodule

// ===== src/parallelogram_rect_overlap_test.sv =====
// Parallelogram versus axis-aligned rectangle overlap test (separating axes).
//
// Input channel: drive the four vertices (signed Q16.8) and the rectangle
// edges (signed integer pixels) with start high; the beat is taken at any
// rising edge where start is high and busy is low. busy is always low, so a
// new beat may be offered on every cycle.
//
// Result channel: done is high for exactly one cycle with overlap valid in
// that same cycle. overlap is 1 when none of the axes x, y, normal(v1-v0),
// normal(v3-v0) separates the shapes; touching intervals count as overlap.
//
// Path: the beat passes the input register, the axis register, the four lane
// stages and the merge register, which drives done and overlap.
// Throughput: one beat per cycle; four lanes, one per axis, run in parallel
// and each lane is a fully pipelined multiply / add / min-max path.
// Results come out in input order. The receiver cannot stall the block.
// Reset (rst_n low, asynchronous) clears all valid flags; beats in flight
// are dropped and no done pulse follows.
module parallelogram_rect_overlap_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [prt_pkg::COORD_W-1:0]  v0_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v0_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v1_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v1_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v2_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v2_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v3_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v3_y,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_min_x,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_min_y,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_max_x,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_max_y,
    output logic                                done,
    output logic                                overlap
);

    // Input register
    logic                                       s0_vld_reg;
    logic [prt_pkg::CORNERS-1:0][prt_pkg::COORD_W-1:0] vx_reg, vy_reg;
    logic signed [prt_pkg::RECT_W-1:0]          rx0_reg, rx1_reg, ry0_reg, ry1_reg;

    // Axis register feeding the lanes
    prt_pkg::lane_in_t                          lane_in_reg  [prt_pkg::LANES];
    prt_pkg::lane_in_t                          lane_in_next [prt_pkg::LANES];
    prt_pkg::lane_res_t                         lane_res     [prt_pkg::LANES];
    logic                                       s1_vld_reg;

    logic signed [prt_pkg::AXIS_W-1:0]          e1_ax, e1_ay, e3_ax, e3_ay;

    assign busy = 1'b0;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start & ~busy;
            s1_vld_reg <= s0_vld_reg;
        end
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        vx_reg  <= {v3_x, v2_x, v1_x, v0_x};
        vy_reg  <= {v3_y, v2_y, v1_y, v0_y};
        rx0_reg <= rect_min_x;
        rx1_reg <= rect_max_x;
        ry0_reg <= rect_min_y;
        ry1_reg <= rect_max_y;
    end

    // Edge normals (ey, -ex) of v1-v0 and v3-v0
    always_comb
    begin
        e1_ax = prt_pkg::AXIS_W'($signed(vy_reg[1])) - prt_pkg::AXIS_W'($signed(vy_reg[0]));
        e1_ay = prt_pkg::AXIS_W'($signed(vx_reg[0])) - prt_pkg::AXIS_W'($signed(vx_reg[1]));
        e3_ax = prt_pkg::AXIS_W'($signed(vy_reg[3])) - prt_pkg::AXIS_W'($signed(vy_reg[0]));
        e3_ay = prt_pkg::AXIS_W'($signed(vx_reg[0])) - prt_pkg::AXIS_W'($signed(vx_reg[3]));
    end

    // Work for each lane
    always_comb
    begin
        for (int k = 0; k < prt_pkg::LANES; k++)
        begin
            lane_in_next[k].vld = s0_vld_reg;
            lane_in_next[k].px  = vx_reg;
            lane_in_next[k].py  = vy_reg;
            lane_in_next[k].rx0 = rx0_reg;
            lane_in_next[k].rx1 = rx1_reg;
            lane_in_next[k].ry0 = ry0_reg;
            lane_in_next[k].ry1 = ry1_reg;
            lane_in_next[k].ax  = '0;
            lane_in_next[k].ay  = '0;
        end
        lane_in_next[prt_pkg::LANE_X].ax  = prt_pkg::AXIS_W'(1);
        lane_in_next[prt_pkg::LANE_Y].ay  = prt_pkg::AXIS_W'(1);
        lane_in_next[prt_pkg::LANE_E1].ax = e1_ax;
        lane_in_next[prt_pkg::LANE_E1].ay = e1_ay;
        lane_in_next[prt_pkg::LANE_E3].ax = e3_ax;
        lane_in_next[prt_pkg::LANE_E3].ay = e3_ay;
    end

    // Axis register: valid bit comes from the reset flop chain
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < prt_pkg::LANES; k++)
        begin
            lane_in_reg[k] <= lane_in_next[k];
        end
    end

    // Lanes
    for (genvar k = 0; k < prt_pkg::LANES; k++)
    begin : g_lane
        prt_pkg::lane_in_t lane_in;

        always_comb
        begin
            lane_in     = lane_in_reg[k];
            lane_in.vld = s1_vld_reg;
        end

        prt_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .lin   (lane_in),
            .lres  (lane_res[k])
        );
    end

    // Merge the lane verdicts
    prt_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .lres    (lane_res),
        .done    (done),
        .overlap (overlap)
    );

endmodule

// ===== sim/overlap_checker.sv =====
// Watches the command and result channels of the overlap test block,
// predicts the overlap bit of every accepted beat and compares in order.
module overlap_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [prt_pkg::COORD_W-1:0]  v0_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v0_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v1_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v1_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v2_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v2_y,
    input  logic signed [prt_pkg::COORD_W-1:0]  v3_x,
    input  logic signed [prt_pkg::COORD_W-1:0]  v3_y,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_min_x,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_min_y,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_max_x,
    input  logic signed [prt_pkg::RECT_W-1:0]   rect_max_y,
    input  logic                                done,
    input  logic                                overlap,
    output int                                  errors,
    output int                                  pending
);

    localparam int MAX_REPORTS = 50;

    // four corners of one shape, each a signed 64-bit coordinate
    typedef logic [prt_pkg::CORNERS-1:0][63:0] corners_t;

    bit overlap_q[$];

    // 1 when the projections of the two shapes onto (ax, ay) leave a gap
    function automatic bit axis_separates(input corners_t px, input corners_t py,
                                          input corners_t rx, input corners_t ry,
                                          input longint ax, input longint ay);
        longint plo, phi, rlo, rhi, dp, dr;
        plo = 0;
        phi = 0;
        rlo = 0;
        rhi = 0;
        for (int i = 0; i < prt_pkg::CORNERS; i++)
        begin
            dp = longint'(px[i]) * ax + longint'(py[i]) * ay;
            dr = longint'(rx[i]) * ax + longint'(ry[i]) * ay;
            if (i == 0)
            begin
                plo = dp;
                phi = dp;
                rlo = dr;
                rhi = dr;
            end
            else
            begin
                if (dp < plo) plo = dp;
                if (dp > phi) phi = dp;
                if (dr < rlo) rlo = dr;
                if (dr > rhi) rhi = dr;
            end
        end
        // touching intervals are not a gap
        return (phi < rlo) || (rhi < plo);
    endfunction

    // separating-axis test over x, y and the normals of edges v1-v0 and v3-v0
    function automatic bit predict_overlap(input longint x0, input longint y0,
                                           input longint x1, input longint y1,
                                           input longint x2, input longint y2,
                                           input longint x3, input longint y3,
                                           input longint lx, input longint ly,
                                           input longint hx, input longint hy);
        corners_t px, py, rx, ry;
        bit gap;
        px[0] = x0; py[0] = y0;
        px[1] = x1; py[1] = y1;
        px[2] = x2; py[2] = y2;
        px[3] = x3; py[3] = y3;
        // rectangle moved onto the Q16.8 grid
        rx[0] = lx * 256; ry[0] = ly * 256;
        rx[1] = hx * 256; ry[1] = ly * 256;
        rx[2] = hx * 256; ry[2] = hy * 256;
        rx[3] = lx * 256; ry[3] = hy * 256;
        gap = axis_separates(px, py, rx, ry, 1, 0)
           || axis_separates(px, py, rx, ry, 0, 1)
           || axis_separates(px, py, rx, ry, y1 - y0, x0 - x1)
           || axis_separates(px, py, rx, ry, y3 - y0, x0 - x3);
        return !gap;
    endfunction

    assign pending = overlap_q.size();

    // result check first, then the new beat, so a same-edge pair stays ordered
    always @(posedge clk)
    begin
        bit want;
        if (!rst_n)
        begin
            overlap_q.delete();
            errors <= 0;
        end
        else
        begin
            if (done)
            begin
                if (overlap_q.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result beat with none expected, overlap %0b",
                                 $time, overlap);
                    errors <= errors + 1;
                end
                else
                begin
                    want = overlap_q.pop_front();
                    if (overlap !== want)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: overlap mismatch, expected %0b, actual %0b",
                                     $time, want, overlap);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                overlap_q.push_back(predict_overlap(v0_x, v0_y, v1_x, v1_y,
                                                    v2_x, v2_y, v3_x, v3_y,
                                                    rect_min_x, rect_min_y,
                                                    rect_max_x, rect_max_y));
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int A               = 2560;     // ten pixels in Q16.8

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [prt_pkg::COORD_W-1:0]     v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y;
    logic signed [prt_pkg::RECT_W-1:0]      rect_min_x, rect_min_y, rect_max_x, rect_max_y;
    logic                                   done;
    logic                                   overlap;
    int                                     errors;
    int                                     pending;
    int                                     idle_pct;

    parallelogram_rect_overlap_test i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .v3_x       (v3_x),
        .v3_y       (v3_y),
        .rect_min_x (rect_min_x),
        .rect_min_y (rect_min_y),
        .rect_max_x (rect_max_x),
        .rect_max_y (rect_max_y),
        .done       (done),
        .overlap    (overlap)
    );

    overlap_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .v3_x       (v3_x),
        .v3_y       (v3_y),
        .rect_min_x (rect_min_x),
        .rect_min_y (rect_min_y),
        .rect_max_x (rect_max_x),
        .rect_max_y (rect_max_y),
        .done       (done),
        .overlap    (overlap),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("parallelogram_rect_overlap_test regression: fail");
        $finish;
    end

    // uniform value in [-n, n]
    function automatic int srand(input int n);
        return int'($urandom_range(2 * n)) - n;
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // one command beat; idles first at the current rate, then holds start
    // until the block takes the beat
    task automatic send_item(input int x0, input int y0, input int x1, input int y1,
                             input int x2, input int y2, input int x3, input int y3,
                             input int lx, input int ly, input int hx, input int hy);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        v0_x       <= x0[prt_pkg::COORD_W-1:0];
        v0_y       <= y0[prt_pkg::COORD_W-1:0];
        v1_x       <= x1[prt_pkg::COORD_W-1:0];
        v1_y       <= y1[prt_pkg::COORD_W-1:0];
        v2_x       <= x2[prt_pkg::COORD_W-1:0];
        v2_y       <= y2[prt_pkg::COORD_W-1:0];
        v3_x       <= x3[prt_pkg::COORD_W-1:0];
        v3_y       <= y3[prt_pkg::COORD_W-1:0];
        rect_min_x <= lx[prt_pkg::RECT_W-1:0];
        rect_min_y <= ly[prt_pkg::RECT_W-1:0];
        rect_max_x <= hx[prt_pkg::RECT_W-1:0];
        rect_max_y <= hy[prt_pkg::RECT_W-1:0];
        do
            @(posedge clk);
        while (busy);
    endtask

    // mostly parallelograms near a rectangle of similar size, at a random
    // scale; some degenerate, skewed, swapped or pure noise beats
    task automatic send_random_item();
        int pick, k, span, lim, cx, cy, e1x, e1y, e3x, e3y, x2, y2;
        int rcx, rcy, hx, hy, r0x, r0y, r1x, r1y, t;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            k    = $urandom_range(20, 4);
            span = 1 << k;
            lim  = (1 << 23) - 4 * span;
            cx   = srand(lim);
            cy   = srand(lim);
            e1x  = srand(span);
            e1y  = srand(span);
            e3x  = srand(span);
            e3y  = srand(span);
            // zero-length edges
            if (pick < 15)
            begin
                e1x = 0;
                e1y = 0;
            end
            else if (pick < 20)
            begin
                e3x = 0;
                e3y = 0;
            end
            x2 = cx + e1x + e3x;
            y2 = cy + e1y + e3y;
            // not a parallelogram: far corner moved
            if (pick >= 20 && pick < 28)
            begin
                x2 = cx + srand(2 * span);
                y2 = cy + srand(2 * span);
            end
            rcx = (cx + srand(3 * span)) >>> 8;
            rcy = (cy + srand(3 * span)) >>> 8;
            hx  = $urandom_range((span >> 8) + 1);
            hy  = $urandom_range((span >> 8) + 1);
            r0x = clamp16(rcx - hx);
            r0y = clamp16(rcy - hy);
            r1x = clamp16(rcx + hx);
            r1y = clamp16(rcy + hy);
            // swapped rectangle bounds
            if (pick >= 28 && pick < 36)
            begin
                t   = r0x;
                r0x = r1x;
                r1x = t;
                t   = r0y;
                r0y = r1y;
                r1y = t;
            end
            send_item(cx, cy, cx + e1x, cy + e1y, x2, y2, cx + e3x, cy + e3y,
                      r0x, r0y, r1x, r1y);
        end
    endtask

    initial
    begin
        int rates[4];
        rates      = '{0, 70, 6, 0};
        idle_pct   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        v0_x       = '0;
        v0_y       = '0;
        v1_x       = '0;
        v1_y       = '0;
        v2_x       = '0;
        v2_y       = '0;
        v3_x       = '0;
        v3_y       = '0;
        rect_min_x = '0;
        rect_min_y = '0;
        rect_max_x = '0;
        rect_max_y = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats
        send_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // square against a rectangle touching its right side, then one pixel off
        send_item(0, 0, A, 0, A, A, 0, A, 10, 0, 20, 10);
        send_item(0, 0, A, 0, A, A, 0, A, 11, 0, 20, 10);
        send_item(0, 0, A, 0, A, A, 0, A, 0, -20, 10, -1);
        send_item(0, 0, A, 0, A, A, 0, A, 0, -20, 10, 0);
        // diamond: only the normal of v3-v0 separates, then a touching contact
        send_item(0, -A, A, 0, 0, A, -A, 0, 6, 6, 10, 10);
        send_item(0, -A, A, 0, 0, A, -A, 0, 5, 5, 10, 10);
        // swapped rectangle bounds
        send_item(0, 0, A, 0, A, A, 0, A, 20, 10, 10, 0);
        send_item(0, 0, A, 0, A, A, 0, A, 25, 15, 11, 0);
        // zero-length edge
        send_item(0, 0, 0, 0, A, A, 0, A, 5, 5, 6, 6);
        // four points that are not a parallelogram
        send_item(0, 0, A, 0, -A, -A, 0, A, -3, -3, -2, -2);
        // field extremes
        send_item(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                  8388607, 8388607, 32767, 32767, 32767, 32767);
        send_item(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                  -8388608, -8388608, -32768, -32768, -32768, -32768);
        send_item(-8388608, -8388608, 8388607, -8388608, 8388607, 8388607,
                  -8388608, 8388607, -32768, -32768, 32767, 32767);
        send_item(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                  -8388607, -8388608, 32767, -32768, 32767, -32768);
        send_item(8388607, -8388608, -8388608, 8388607, 8388607, 8388607,
                  -8388608, -8388608, -32768, 32767, 32767, -32768);
        send_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_item('h555555, 'haaaaaa, 'haaaaaa, 'h555555, 'h555555, 'haaaaaa,
                  'haaaaaa, 'h555555, 'h5555, 'haaaa, 'haaaa, 'h5555);

        // random beats over several idle rates
        foreach (rates[p])
        begin
            idle_pct = rates[p];
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        start <= 1'b0;

        // drain the pipeline, then watch for stray result beats
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("parallelogram_rect_overlap_test regression: pass");
        else
            $display("parallelogram_rect_overlap_test regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/prt_pkg.sv
src/prt_lane.sv
src/prt_merge.sv
src/parallelogram_rect_overlap_test.sv
sim/overlap_checker.sv
sim/testbench.sv
